[src/aes_pkg.sv]
// AES-128 package: S-box, round step, key-schedule step and shared constants.
// Used by every module of the block encryptor; depends on nothing.
`default_nettype none
package aes_pkg;

   localparam int KeyWidth     = 128;
   localparam int HalfWidth    = 64;
   localparam int CsrIdxWidth  = 1;
   localparam int NumRounds    = 10;
   localparam int RconWidth    = 8;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CsrKeyHigh = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLow  = 1'b1;

   localparam logic [7:0] ReducePoly = 8'h1b;
   localparam logic [7:0] FirstRcon  = 8'h01;

   typedef logic [KeyWidth-1:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] v);
      logic [7:0] r;
      case (v)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return v[7] ? ({v[6:0], 1'b0} ^ ReducePoly) : {v[6:0], 1'b0};
   endfunction

   // byte i of a block, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[KeyWidth-1-8*i -: 8];
   endfunction

   // SubBytes, ShiftRows and optional MixColumns
   function automatic block_type round_core(input block_type s, input logic mix);
      block_type  t;
      block_type  o;
      logic [7:0] a, b, d, e, all;
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            t[KeyWidth-1-8*(4*c+i) -: 8] = sbox(get_byte(s, 4*((c+i)%4)+i));
      o = t;
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a = get_byte(t, 4*c);
            b = get_byte(t, 4*c+1);
            d = get_byte(t, 4*c+2);
            e = get_byte(t, 4*c+3);
            all = a ^ b ^ d ^ e;
            o[KeyWidth-1-8*(4*c)   -: 8] = a ^ all ^ xtime(a ^ b);
            o[KeyWidth-1-8*(4*c+1) -: 8] = b ^ all ^ xtime(b ^ d);
            o[KeyWidth-1-8*(4*c+2) -: 8] = d ^ all ^ xtime(d ^ e);
            o[KeyWidth-1-8*(4*c+3) -: 8] = e ^ all ^ xtime(e ^ a);
         end
      end
      return o;
   endfunction

   // next round key from the previous one and its round constant
   function automatic block_type key_step(input block_type k, input logic [7:0] rcon);
      logic [31:0] t;
      logic [31:0] w0, w1, w2, w3;
      t = {sbox(k[23:16]) ^ rcon, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
      w0 = k[127:96] ^ t;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage
`default_nettype wire

[src/aes_stream_if.sv]
// Valid/ready stream interface carrying one AES block and its last flag.
// Depends on aes_pkg for the block width.
`default_nettype none
interface aes_stream_if import aes_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [HalfWidth-1:0] data_high;
   logic [HalfWidth-1:0] data_low;
   logic               last;

   modport source (output valid, output data_high, output data_low, output last,
                   input ready);
   modport sink   (input valid, input data_high, input data_low, input last,
                   output ready);
endinterface
`default_nettype wire

[src/aes_round_cell.sv]
// One cell of the round chain: a round on the state plus one key-schedule step.
// Depends on aes_pkg.
`default_nettype none
module aes_round_cell
   import aes_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       final_round,
   input  wire logic       valid_in,
   input  wire block_type  state_in,
   input  wire block_type  key_in,
   input  wire logic [7:0] rcon_in,
   input  wire logic       last_in,
   output logic            valid_out,
   output block_type       state_out,
   output block_type       key_out,
   output logic [7:0]      rcon_out,
   output logic            last_out
);
   logic       valid_ff;
   block_type  state_ff;
   block_type  key_ff;
   logic [7:0] rcon_ff;
   logic       last_ff;
   block_type  key_in_next;
   block_type  state_in_next;

   // derive this round's key and apply the round
   always_comb begin
      key_in_next   = key_step(key_in, rcon_in);
      state_in_next = round_core(state_in, ~final_round) ^ key_in_next;
   end

   // control: valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // payload: hand to the next cell
   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in_next;
         key_ff   <= key_in_next;
         rcon_ff  <= xtime(rcon_in);
         last_ff  <= last_in;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;
   assign rcon_out  = rcon_ff;
   assign last_out  = last_ff;
endmodule
`default_nettype wire

[src/aes128_block_encryptor.sv]
// Top level of the AES-128 ECB encryptor: key registers, key-add entry stage,
// chain of aes_round_cell instances. Depends on aes_pkg and aes_stream_if.
//
// Channel  Dir  Payload                         Transfer
// req      in   plain_high, plain_low, last_in  req.valid & req.ready
// rsp      out  cipher_high, cipher_low, last   rsp.valid & rsp.ready
// csr      in   csr_index, csr_data (64 bits)   csr_write_en
//
// One block per cycle sustained while rsp does not stall; the pipeline is the entry key add plus ten
// round cells. Each cell carries its own round key from the one before it.
// The whole chain advances together when the last cell is empty or taken;
// a stall at rsp holds every stage. Reset clears valid bits and the key.
`default_nettype none
module aes128_block_encryptor
   import aes_pkg::*;
#(
   parameter int Rounds = NumRounds
)(
   input  wire logic                    clock,
   input  wire logic                    reset,
   aes_stream_if.sink                   req,
   aes_stream_if.source                 rsp,
   input  wire logic                    csr_write_en,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [HalfWidth-1:0]    csr_data
);
   logic [HalfWidth-1:0] key_high_ff;
   logic [HalfWidth-1:0] key_low_ff;
   logic                 advance;
   logic                 entry_valid_ff;
   block_type            entry_state_ff;
   block_type            entry_key_ff;
   logic                 entry_last_ff;

   logic       valid_c [Rounds+1];
   block_type  state_c [Rounds+1];
   block_type  key_c   [Rounds+1];
   logic [7:0] rcon_c  [Rounds+1];
   logic       last_c  [Rounds+1];

   // write key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CsrKeyHigh: key_high_ff <= csr_data;
            CsrKeyLow:  key_low_ff  <= csr_data;
            default:    ;
         endcase
      end
   end

   assign advance   = ~valid_c[Rounds] | rsp.ready;
   assign req.ready = advance;

   // entry stage: initial key add
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_key_ff   <= {key_high_ff, key_low_ff};
         entry_state_ff <= {req.data_high, req.data_low} ^ {key_high_ff, key_low_ff};
         entry_last_ff  <= req.last;
      end
   end

   assign valid_c[0] = entry_valid_ff;
   assign state_c[0] = entry_state_ff;
   assign key_c[0]   = entry_key_ff;
   assign rcon_c[0]  = FirstRcon;
   assign last_c[0]  = entry_last_ff;

   // chain of round cells
   for (genvar r = 0; r < Rounds; r++) begin : g_round
      aes_round_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .final_round (r == Rounds - 1),
         .valid_in    (valid_c[r]),
         .state_in    (state_c[r]),
         .key_in      (key_c[r]),
         .rcon_in     (rcon_c[r]),
         .last_in     (last_c[r]),
         .valid_out   (valid_c[r+1]),
         .state_out   (state_c[r+1]),
         .key_out     (key_c[r+1]),
         .rcon_out    (rcon_c[r+1]),
         .last_out    (last_c[r+1])
      );
   end

   assign rsp.valid     = valid_c[Rounds];
   assign rsp.data_high = state_c[Rounds][KeyWidth-1:HalfWidth];
   assign rsp.data_low  = state_c[Rounds][HalfWidth-1:0];
   assign rsp.last      = last_c[Rounds];
endmodule
`default_nettype wire

[sim/aes128_encrypt_checker.sv]
// Checker for the AES-128 block encryptor: watches the key write port and both
// streams, predicts each ciphertext and compares it. Depends on aes_pkg, aes_stream_if.
module aes128_encrypt_checker
   import aes_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   aes_stream_if                       req,
   aes_stream_if                       rsp,
   input  wire logic                   csr_write_en,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [HalfWidth-1:0]   csr_data,
   output int                          fail_count,
   output int                          pending
);

   typedef struct packed {
      logic [HalfWidth-1:0] cipher_high;
      logic [HalfWidth-1:0] cipher_low;
      logic                 last_out;
   } cipher_item_type;

   logic [7:0]          sub_lut [256];
   logic [HalfWidth-1:0] key_high_q;
   logic [HalfWidth-1:0] key_low_q;
   cipher_item_type     cipher_q [$];

   function automatic logic [7:0] gf_double(input logic [7:0] v);
      return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_double(a);
      end
      return p;
   endfunction

   // Build the substitution table from the field inverse and the affine map
   initial begin
      logic [7:0] inv, b;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h01;
         for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
         b = inv;
         sub_lut[x] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                      ^ {b[3:0], b[7:4]} ^ 8'h63;
      end
   end

   function automatic logic [127:0] predict_cipher(input logic [127:0] key,
                                                   input logic [127:0] blk);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] f, a, b, d, e, all, rc;
      logic [127:0] out;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127-8*i -: 8];
         s[i]  = blk[127-8*i -: 8] ^ rk[i];
      end
      // Expand the key word by word
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
         if ((i % 4) == 0) begin
            f = w[0];
            w[0] = sub_lut[w[1]] ^ rc;
            w[1] = sub_lut[w[2]];
            w[2] = sub_lut[w[3]];
            w[3] = sub_lut[f];
            rc = gf_double(rc);
         end
         for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
      end
      // Nine full rounds and a final round without column mixing
      for (int r = 1; r <= NumRounds; r++) begin
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
               t[4*c+i] = sub_lut[s[4*((c+i)%4)+i]];
         for (int c = 0; c < 4; c++) begin
            a = t[4*c]; b = t[4*c+1]; d = t[4*c+2]; e = t[4*c+3];
            if (r < NumRounds) begin
               all = a ^ b ^ d ^ e;
               s[4*c]   = a ^ all ^ gf_double(a ^ b);
               s[4*c+1] = b ^ all ^ gf_double(b ^ d);
               s[4*c+2] = d ^ all ^ gf_double(d ^ e);
               s[4*c+3] = e ^ all ^ gf_double(e ^ a);
            end else begin
               s[4*c] = a; s[4*c+1] = b; s[4*c+2] = d; s[4*c+3] = e;
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= rk[16*r+i];
      end
      for (int i = 0; i < 16; i++) out[127-8*i -: 8] = s[i];
      return out;
   endfunction

   assign pending = cipher_q.size();

   // Track key writes, queue predictions, compare results
   always @(posedge clock) begin
      logic [127:0] ct;
      cipher_item_type got, exp_item;
      if (reset) begin
         key_high_q <= '0;
         key_low_q  <= '0;
         cipher_q.delete();
      end else begin
         if (req.valid && req.ready) begin
            ct = predict_cipher({key_high_q, key_low_q}, {req.data_high, req.data_low});
            cipher_q.push_back('{ct[127:64], ct[63:0], req.last});
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.data_high, rsp.data_low, rsp.last};
            if (cipher_q.size() == 0) begin
               $error("unexpected transfer: cipher_high %h cipher_low %h",
                      got.cipher_high, got.cipher_low);
               fail_count++;
            end else begin
               exp_item = cipher_q.pop_front();
               if (got.cipher_high !== exp_item.cipher_high) begin
                  $error("cipher_high expected %h actual %h",
                         exp_item.cipher_high, got.cipher_high);
                  fail_count++;
               end
               if (got.cipher_low !== exp_item.cipher_low) begin
                  $error("cipher_low expected %h actual %h",
                         exp_item.cipher_low, got.cipher_low);
                  fail_count++;
               end
               if (got.last_out !== exp_item.last_out) begin
                  $error("last_out expected %b actual %b", exp_item.last_out, got.last_out);
                  fail_count++;
               end
            end
         end
         if (csr_write_en) begin
            if (csr_index == CsrKeyHigh) key_high_q <= csr_data;
            else if (csr_index == CsrKeyLow) key_low_q <= csr_data;
         end
      end
   end

   initial fail_count = 0;

endmodule

[sim/tb_aes128_block_encryptor.sv]
// Top of the AES-128 block encryptor testbench: clock, reset, key writes,
// plaintext stimulus, result back-pressure and verdict. Depends on the checker.
module tb_aes128_block_encryptor;
   import aes_pkg::*;

   localparam int IdleLimit = 1000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [HalfWidth-1:0]   csr_data;
   logic                   quiet;
   logic                   stall_rsp;
   logic                   stall_served;
   int                     fail_count;
   int                     pending;
   int                     idle_cycles;

   aes_stream_if req_if ();
   aes_stream_if rsp_if ();

   aes128_block_encryptor DUT (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   aes128_encrypt_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [HalfWidth-1:0] rand_half();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Pulse the write enable for one cycle, then return with it held low
   task automatic write_key(input logic [CsrIdxWidth-1:0] idx, input logic [HalfWidth-1:0] v);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one block, optionally after a short gap, and hold until transfer
   task automatic send_block(input logic [HalfWidth-1:0] hi, input logic [HalfWidth-1:0] lo,
                             input logic last);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_high <= hi;
      req_if.data_low  <= lo;
      req_if.last      <= last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid, wait for every result, then let the clock run on before returning
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (12) @(posedge clock);
   endtask

   // Result side: random back-pressure and one long hold-off
   initial begin
      stall_served = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_rsp && !stall_served) begin
            rsp_if.ready <= 1'b0;
            stall_served = 1'b1;
            repeat (60) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (quiet || reset || $urandom_range(0, 3) != 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles without any transfer
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("aes128_block_encryptor: mismatch");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_high = '0;
      req_if.data_low  = '0;
      req_if.last      = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = CsrKeyHigh;
      csr_data         = '0;
      quiet            = 1'b0;
      stall_rsp        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset key of zero: field extremes and the last flag both ways
      send_block('0, '0, 1'b0);
      send_block('1, '1, 1'b1);
      send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
      send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1);
      drain();

      // Standard test vector, then same plaintext under an all-ones key
      write_key(CsrKeyHigh, 64'h0001_0203_0405_0607);
      write_key(CsrKeyLow,  64'h0809_0a0b_0c0d_0e0f);
      send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b1);
      send_block('0, '0, 1'b0);
      send_block('1, '0, 1'b1);
      drain();
      write_key(CsrKeyHigh, '1);
      write_key(CsrKeyLow,  '1);
      send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b0);
      send_block('0, '1, 1'b1);
      // Key change: only one half differs from the previous key
      drain();
      write_key(CsrKeyLow, '0);
      for (int i = 0; i < 8; i++)
         send_block(64'h1 << (8 * i), 64'h80 << (8 * i), i[0]);
      drain();

      // Random phases, each under a fresh key
      for (int phase = 0; phase < 4; phase++) begin
         write_key(CsrKeyHigh, rand_half());
         write_key(CsrKeyLow,  rand_half());
         if (phase == 3) quiet = 1'b1;
         for (int n = 0; n < 170; n++) begin
            if (phase == 1 && n == 30) stall_rsp = 1'b1;
            send_block(rand_half(), rand_half(), 1'($urandom_range(0, 1)));
         end
         drain();
      end

      if (fail_count == 0)
         $display("aes128_block_encryptor: match");
      else
         $display("aes128_block_encryptor: mismatch");
      $finish;
   end

endmodule

[filelist.f]
src/aes_pkg.sv
src/aes_stream_if.sv
src/aes_round_cell.sv
src/aes128_block_encryptor.sv
sim/aes128_encrypt_checker.sv
sim/tb_aes128_block_encryptor.sv
